/* rtl/wbm_pkg.sv */
// Package for the weighted breakpoint morph block: field widths, operation
// and status codes, and the command word passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
package wbm_pkg;
  localparam int IN_W  = 64;
  localparam int OUT_W = 32;
  localparam int MAX_EMIT = 32;

  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_ADD   = 2'd1;
  localparam logic [1:0] FN_WRITE = 2'd2;
  localparam logic [1:0] FN_QUERY = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOPOINT = 2'd2;

  localparam logic [16:0] ONE_Q16      = 17'h10000;
  localparam logic [15:0] WEIGHT_FLOOR = 16'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [16:0]        position;
    logic [15:0]        blend;
    logic [4:0]         element_index;
    logic signed [23:0] element_value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;
endpackage

/* rtl/wbm_ram.sv */
// Generic memory with one write port and two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
module wbm_ram #(
  parameter int W = 24,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr_a,
  input  logic [$clog2(D)-1:0] raddr_b,
  output logic [W-1:0]         rdata_a,
  output logic [W-1:0]         rdata_b
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

/* rtl/wbm_div.sv */
// Shift-and-subtract unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module wbm_div #(
  parameter int NW = 50,
  parameter int DW = 34,
  parameter int QB = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QB-1:0] quo
);
  localparam int RW = DW + QB;
  localparam int JW = $clog2(QB);

  logic [RW-1:0] rem;
  logic [DW-1:0] dv;
  logic [JW-1:0] j;
  logic          busy;
  logic [RW-1:0] dd;
  logic          ge;

  assign dd = RW'(dv) << j;
  assign ge = rem >= dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (j == '0);
      if (start) begin
        busy <= 1'b1;
        rem  <= RW'(num);
        dv   <= den;
        j    <= JW'(QB - 1);
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dd;
        end
        quo <= {quo[QB-2:0], ge};
        if (j == '0) begin
          busy <= 1'b0;
        end else begin
          j <= j - 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/wbm_front.sv */
// Front end: accepts input words, saturates the position and holds them in a
// two-entry queue for the back end. Depends on wbm_pkg.
`timescale 1ns / 1ps
module wbm_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [wbm_pkg::IN_W-1:0] s_tdata,
  output wbm_pkg::head_t           head,
  input  logic                     head_pop
);
  import wbm_pkg::*;

  cmd_t       ent [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       inc;
  logic       push, pop;

  always_comb begin
    inc.func          = s_tdata[1:0];
    inc.position      = (s_tdata[18:2] > ONE_Q16) ? ONE_Q16 : s_tdata[18:2];
    inc.blend         = s_tdata[34:19];
    inc.element_index = s_tdata[39:35];
    inc.element_value = s_tdata[63:40];
  end

  assign s_tready   = cnt != 2'd2;
  assign push       = s_tvalid && s_tready;
  assign pop        = head_pop && (cnt != 2'd0);
  assign head.valid = cnt != 2'd0;
  assign head.cmd   = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        ent[wp] <= inc;
        wp      <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/wbm_engine.sv */
// Back end: breakpoint table, profile memory, weight divider and the result
// sequencer. Depends on wbm_pkg, wbm_ram and wbm_div.
`timescale 1ns / 1ps
module wbm_engine #(
  parameter int MAX_POINTS  = 8,
  parameter int PROFILE_LEN = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  wbm_pkg::head_t            head,
  output logic                      head_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [wbm_pkg::OUT_W-1:0] m_tdata,
  output logic [1:0]                m_tuser,
  output logic                      m_tlast
);
  import wbm_pkg::*;

  localparam int RIW = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int DEP = MAX_POINTS * PROFILE_LEN;
  localparam int AW  = $clog2(DEP);
  localparam int EW  = $clog2(PROFILE_LEN + 1);
  localparam int N   = (PROFILE_LEN < MAX_EMIT) ? PROFILE_LEN : MAX_EMIT;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_ZERO  = 4'd2;
  localparam logic [3:0] S_ACK   = 4'd3;
  localparam logic [3:0] S_SRCH  = 4'd4;
  localparam logic [3:0] S_DIV1  = 4'd5;
  localparam logic [3:0] S_WAIT1 = 4'd6;
  localparam logic [3:0] S_MULW  = 4'd7;
  localparam logic [3:0] S_DEN   = 4'd8;
  localparam logic [3:0] S_DIV2  = 4'd9;
  localparam logic [3:0] S_WAIT2 = 4'd10;
  localparam logic [3:0] S_ERD   = 4'd11;
  localparam logic [3:0] S_EMUL  = 4'd12;
  localparam logic [3:0] S_ESUM  = 4'd13;

  logic [3:0]     state, state_next;
  cmd_t           cmd;
  logic [CW-1:0]  count;
  logic [RIW-1:0] newest;
  logic [16:0]    rpos  [MAX_POINTS];
  logic [15:0]    rwt   [MAX_POINTS];
  logic [RIW-1:0] rslot [MAX_POINTS];
  logic [1:0]     st;
  logic [EW-1:0]  ei;
  logic [RIW-1:0] sa, sb;
  logic [16:0]    pa, pb, t, tw;
  logic [15:0]    wa, wb;
  logic           zero_out;
  logic [32:0]    pd_a, pd_b;
  logic [33:0]    den;
  logic signed [41:0] pm_a, pm_b, vsum;

  logic            out_free;
  logic            emit;
  logic [MAX_POINTS-1:0] le, hit;
  logic [RIW-1:0]  hk;
  logic [RIW-1:0]  lastr;
  logic [16:0]     range;
  logic            div_start, div_done;
  logic [49:0]     div_num;
  logic [33:0]     div_den;
  logic [17:0]     quo;
  logic [16:0]     qclamp;
  logic            we;
  logic [AW-1:0]   waddr, raddr_a, raddr_b;
  logic [23:0]     wdata;
  logic [23:0]     rdata_a, rdata_b;

  assign out_free = !m_tvalid || m_tready;
  assign emit     = ((state == S_ACK) || (state == S_ESUM)) && out_free;
  assign lastr    = RIW'(count - 1'b1);
  assign range    = pb - pa;
  assign qclamp   = (quo > 18'(ONE_Q16)) ? ONE_Q16 : quo[16:0];
  assign vsum     = pm_a + pm_b + 42'sd32768;
  assign head_pop = (state == S_IDLE) && head.valid;

  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      le[k] = (CW'(k) < count) && (rpos[k] <= cmd.position);
    end
    hit = '0;
    for (int k = 0; k + 1 < MAX_POINTS; k++) begin
      hit[k] = (CW'(k + 1) < count) && (rpos[k] <= cmd.position)
               && (cmd.position <= rpos[k + 1]);
    end
    hk = '0;
    for (int k = MAX_POINTS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hk = RIW'(k);
      end
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {17'd0, cmd.position - pa, 16'd0};
    div_den   = 34'(range);
    if (state == S_DIV1) begin
      div_start = range != '0;
    end else if (state == S_DIV2) begin
      div_start = 1'b1;
      div_num   = {1'b0, pd_b, 16'd0} + 50'(den >> 1);
      div_den   = den;
    end
  end

  always_comb begin
    we      = 1'b0;
    waddr   = AW'(newest) * AW'(PROFILE_LEN) + AW'(cmd.element_index);
    wdata   = cmd.element_value;
    raddr_a = AW'(sa) * AW'(PROFILE_LEN) + AW'(ei);
    raddr_b = AW'(sb) * AW'(PROFILE_LEN) + AW'(ei);
    if (state == S_ZERO) begin
      we    = 1'b1;
      waddr = AW'(newest) * AW'(PROFILE_LEN) + AW'(ei);
      wdata = '0;
    end else if (state == S_DISP && cmd.func == FN_WRITE && count != '0
                 && 32'(cmd.element_index) < PROFILE_LEN) begin
      we = 1'b1;
    end
  end

  wbm_ram #(.W(24), .D(DEP)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  wbm_div #(.NW(50), .DW(34), .QB(18)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (head.valid) state_next = S_DISP;
      S_DISP: begin
        case (cmd.func)
          FN_ADD:   state_next = (count >= CW'(MAX_POINTS)) ? S_ACK : S_ZERO;
          FN_QUERY: state_next = S_SRCH;
          default:  state_next = S_ACK;
        endcase
      end
      S_ZERO:  if (ei == EW'(PROFILE_LEN - 1)) state_next = S_ACK;
      S_ACK:   if (out_free) state_next = S_IDLE;
      S_SRCH: begin
        if (count == '0 || count == CW'(1) || cmd.position <= rpos[0]
            || cmd.position >= rpos[lastr]) begin
          state_next = S_ERD;
        end else begin
          state_next = S_DIV1;
        end
      end
      S_DIV1:  state_next = (range != '0) ? S_WAIT1 : S_MULW;
      S_WAIT1: if (div_done) state_next = S_MULW;
      S_MULW:  state_next = S_DEN;
      S_DEN:   state_next = S_DIV2;
      S_DIV2:  state_next = S_WAIT2;
      S_WAIT2: if (div_done) state_next = S_ERD;
      S_ERD:   state_next = S_EMUL;
      S_EMUL:  state_next = S_ESUM;
      S_ESUM: begin
        if (out_free) begin
          state_next = (ei == EW'(N - 1)) ? S_IDLE : S_ERD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      newest   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            cmd <= head.cmd;
          end
          st <= ST_OK;
          ei <= '0;
        end
        S_DISP: begin
          case (cmd.func)
            FN_CLEAR: begin
              count  <= '0;
              newest <= '0;
            end
            FN_ADD: begin
              if (count >= CW'(MAX_POINTS)) begin
                st <= ST_FULL;
              end else begin
                for (int k = 0; k < MAX_POINTS; k++) begin
                  if (!le[k] && CW'(k) <= count) begin
                    if (k == 0 || le[(k == 0) ? 0 : k - 1]) begin
                      rpos[k]  <= cmd.position;
                      rwt[k]   <= cmd.blend;
                      rslot[k] <= RIW'(count);
                    end else begin
                      rpos[k]  <= rpos[(k == 0) ? 0 : k - 1];
                      rwt[k]   <= rwt[(k == 0) ? 0 : k - 1];
                      rslot[k] <= rslot[(k == 0) ? 0 : k - 1];
                    end
                  end
                end
                count  <= count + 1'b1;
                newest <= RIW'(count);
              end
            end
            FN_WRITE: begin
              if (count == '0) begin
                st <= ST_NOPOINT;
              end
            end
            default: ;
          endcase
        end
        S_ZERO: ei <= ei + 1'b1;
        S_ACK: begin
          if (out_free) begin
            m_tdata <= '0;
            m_tuser <= st;
            m_tlast <= 1'b1;
          end
        end
        S_SRCH: begin
          zero_out <= count == '0;
          tw       <= '0;
          ei       <= '0;
          if (count == CW'(1) || cmd.position <= rpos[0]) begin
            sa <= rslot[0];
            sb <= rslot[0];
          end else if (cmd.position >= rpos[lastr]) begin
            sa <= rslot[lastr];
            sb <= rslot[lastr];
          end else begin
            sa <= rslot[hk];
            sb <= rslot[RIW'(hk + 1'b1)];
            pa <= rpos[hk];
            pb <= rpos[RIW'(hk + 1'b1)];
            wa <= (rwt[hk] < WEIGHT_FLOOR) ? WEIGHT_FLOOR : rwt[hk];
            wb <= (rwt[RIW'(hk + 1'b1)] < WEIGHT_FLOOR) ? WEIGHT_FLOOR
                                                         : rwt[RIW'(hk + 1'b1)];
          end
        end
        S_DIV1:  if (range == '0) t <= '0;
        S_WAIT1: if (div_done) t <= qclamp;
        S_MULW: begin
          pd_a <= wa * (ONE_Q16 - t);
          pd_b <= wb * t;
        end
        S_DEN:   den <= {1'b0, pd_a} + {1'b0, pd_b};
        S_WAIT2: if (div_done) tw <= qclamp;
        S_EMUL: begin
          pm_a <= $signed(rdata_a) * $signed({1'b0, ONE_Q16 - tw});
          pm_b <= $signed(rdata_b) * $signed({1'b0, tw});
        end
        S_ESUM: begin
          if (out_free) begin
            m_tdata  <= {3'd0, (zero_out ? 24'd0 : vsum[39:16]), 5'(ei)};
            m_tuser  <= ST_OK;
            m_tlast  <= ei == EW'(N - 1);
            ei       <= ei + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

/* rtl/weighted_breakpoint_morph.sv */
// Top level of the weighted breakpoint morph block: input queue and back end.
// Depends on wbm_pkg, wbm_front and wbm_engine.
`timescale 1ns / 1ps
// Each input word is one command: clear, add a breakpoint, write a profile
// element of the newest breakpoint, or query. Clear and write give one word.
// An add that finds room gives one word once the new breakpoint's profile is
// zeroed, one memory entry a cycle. A query emits min(PROFILE_LEN, 32) words,
// each through memory read, multiply and round; a query that falls between
// two breakpoints first uses the shared divider, which makes one quotient bit
// a cycle, for t and then for the weighted factor. Two further commands are
// queued while one executes.
module weighted_breakpoint_morph #(
  parameter int MAX_POINTS  = 8,
  parameter int PROFILE_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // func, position, blend, element_index, element_value
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // element_index_res, element_value_res, zero padding
  output logic [31:0] m_tdata,
  // status
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);
  import wbm_pkg::*;

  head_t head;
  logic  head_pop;

  wbm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .head     (head),
    .head_pop (head_pop)
  );

  wbm_engine #(.MAX_POINTS(MAX_POINTS), .PROFILE_LEN(PROFILE_LEN)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .head_pop (head_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );
endmodule

/* rtl/wbm_checker.sv */
// Port checker for the weighted breakpoint morph block, bound to the top level.
// Depends on wbm_pkg and weighted_breakpoint_morph.
`timescale 1ns / 1ps
module wbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import wbm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_ack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == '0)
    else $error("error acknowledgement carries data");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == ST_OK)
    else $error("error status inside a query run");
endmodule

bind weighted_breakpoint_morph wbm_checker u_wbm_checker (.*);
